@@ rtl/spq_pkg.sv @@
// Shared constants, codes and control types for the sorted priority queue.
package spq_pkg;

  // Queue geometry and field widths
  localparam int DEPTH     = 8;
  localparam int PRIO_BITS = 8;
  localparam int TAG_BITS  = 32;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int FILL_BITS = 4;
  localparam int STAT_BITS = 2;

  // Request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STAT_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;

  // Controller states
  typedef enum logic {
    CS_IDLE,
    CS_EXEC
  } ctl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // apply it to the queue and write the result register
  } dp_cmd_t;

endpackage

@@ rtl/spq_ctrl.sv @@
// Controller: request/result handshake sequencing for the sorted priority queue.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output logic    res_valid,
  input  logic    res_stall,
  output dp_cmd_t cmd
);

  ctl_state_t state;
  ctl_state_t state_next;
  logic       res_valid_next;
  logic       res_free;

  // Result register can take a new value when empty or being drained
  assign res_free = !res_valid || !res_stall;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    req_stall      = 1'b1;
    cmd.load       = 1'b0;
    cmd.exec       = 1'b0;
    res_valid_next = res_valid && res_stall;
    case (state)
      CS_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (res_free) begin
          cmd.exec       = 1'b1;
          res_valid_next = 1'b1;
          state_next     = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/spq_datapath.sv @@
// Datapath: sorted entry cells, request capture and result register.
module spq_datapath
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  input  logic                 kind,
  input  logic [PRIO_BITS-1:0] prio,
  input  logic [TAG_BITS-1:0]  tag,
  output logic [STAT_BITS-1:0] status,
  output logic [PRIO_BITS-1:0] out_prio,
  output logic [TAG_BITS-1:0]  out_tag,
  output logic [FILL_BITS-1:0] fill
);

  logic                 kind_q;
  logic [PRIO_BITS-1:0] prio_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [CNT_BITS-1:0]  cnt;
  logic [CNT_BITS-1:0]  cnt_next;
  logic [PRIO_BITS-1:0] entry_prio [DEPTH];
  logic [TAG_BITS-1:0]  entry_tag  [DEPTH];
  logic [DEPTH-1:0]     place;     // cell lies at or after the insert slot
  logic                 is_full;
  logic                 is_empty;
  logic                 do_insert;
  logic                 do_remove;

  assign is_full   = (cnt == CNT_BITS'(DEPTH));
  assign is_empty  = (cnt == '0);
  assign do_insert = (kind_q == KIND_INSERT) && !is_full;
  assign do_remove = (kind_q == KIND_REMOVE) && !is_empty;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      prio_q <= prio;
      tag_q  <= tag;
    end
  end

  // Per-cell compare: held entries larger than the new one move back
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      place[i] = ((CNT_BITS'(i) < cnt) && (entry_prio[i] > prio_q)) ||
                 (CNT_BITS'(i) == cnt);
    end
  end

  // Entry count
  always_comb begin
    cnt_next = cnt;
    if (do_insert) begin
      cnt_next = cnt + 1'b1;
    end else if (do_remove) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.exec) begin
      cnt <= cnt_next;
    end
  end

  // Entry cells: insert shifts back from the slot, remove shifts all forward
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_insert && place[i]) begin
          if (i == 0) begin
            entry_prio[i] <= prio_q;
            entry_tag[i]  <= tag_q;
          end else if (!place[i-1]) begin
            entry_prio[i] <= prio_q;
            entry_tag[i]  <= tag_q;
          end else begin
            entry_prio[i] <= entry_prio[i-1];
            entry_tag[i]  <= entry_tag[i-1];
          end
        end else if (do_remove && (i < DEPTH - 1)) begin
          entry_prio[i] <= entry_prio[i+1];
          entry_tag[i]  <= entry_tag[i+1];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      fill <= FILL_BITS'(cnt_next);
      if (do_remove) begin
        status   <= ST_DONE;
        out_prio <= entry_prio[0];
        out_tag  <= entry_tag[0];
      end else begin
        out_prio <= '0;
        out_tag  <= '0;
        if (do_insert) begin
          status <= ST_DONE;
        end else if (kind_q == KIND_INSERT) begin
          status <= ST_FULL;
        end else begin
          status <= ST_EMPTY;
        end
      end
    end
  end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: controller plus datapath.
//
//   channel   valid       stall       payload
//   request   req_valid   req_stall   kind, prio, tag
//   result    res_valid   res_stall   status, out_prio, out_tag, fill
//
// Each request is captured first and then executed: all entry cells
// compare against the new priority and shift in parallel.
// A new request is taken while the previous result still waits in the
// result register; execution waits only until that register is free.
// rst (synchronous) empties the queue and drops any pending result.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 kind,
  input  logic [PRIO_BITS-1:0] prio,
  input  logic [TAG_BITS-1:0]  tag,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [STAT_BITS-1:0] status,
  output logic [PRIO_BITS-1:0] out_prio,
  output logic [TAG_BITS-1:0]  out_tag,
  output logic [FILL_BITS-1:0] fill
);

  dp_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd)
  );

  spq_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .kind     (kind),
    .prio     (prio),
    .tag      (tag),
    .status   (status),
    .out_prio (out_prio),
    .out_tag  (out_tag),
    .fill     (fill)
  );

`ifndef NO_ASSERTIONS
  // One request in flight: after a capture the request side stalls
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> req_stall)
    else $error("request accepted while another is in flight");

  // Refused insert only when the queue is full
  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_FULL) |-> (fill == FILL_BITS'(DEPTH)))
    else $error("insert refused with room left");

  // Refused remove only when the queue is empty
  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_EMPTY) |-> (fill == '0))
    else $error("remove refused with entries held");

  // Every executed request leaves a result waiting
  a_exec_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> res_valid)
    else $error("executed request left no result");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the sorted priority queue: directed, random and backpressure tests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    logic [STAT_BITS-1:0] status;
    logic [PRIO_BITS-1:0] out_prio;
    logic [TAG_BITS-1:0]  out_tag;
    logic [FILL_BITS-1:0] fill;
  } spq_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic                 kind = KIND_INSERT;
  logic [PRIO_BITS-1:0] prio = '0;
  logic [TAG_BITS-1:0]  tag = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [STAT_BITS-1:0] status;
  logic [PRIO_BITS-1:0] out_prio;
  logic [TAG_BITS-1:0]  out_tag;
  logic [FILL_BITS-1:0] fill;

  // Shadow copy of the queue contents
  logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
  logic [TAG_BITS-1:0]  shadow_tag  [DEPTH];
  int                   shadow_count = 0;

  spq_result_t pending_results[$];
  spq_result_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int cycles        = 0;
  int errors        = 0;
  int n_requests    = 0;
  int n_results     = 0;
  int n_full        = 0;
  int n_empty       = 0;

  sorted_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .prio      (prio),
    .tag       (tag),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .out_prio  (out_prio),
    .out_tag   (out_tag),
    .fill      (fill)
  );

  always #2 clk = ~clk;

  // Apply one request to the shadow queue and return the result it must give
  function automatic spq_result_t queue_apply(input logic k, input logic [PRIO_BITS-1:0] p,
                                              input logic [TAG_BITS-1:0] t);
    spq_result_t r;
    int pos;
    r.status   = ST_DONE;
    r.out_prio = '0;
    r.out_tag  = '0;
    if (k == KIND_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // slide strictly larger priorities back; ties stay ahead of the newcomer
        pos = shadow_count;
        while (pos > 0 && shadow_prio[pos-1] > p) begin
          shadow_prio[pos] = shadow_prio[pos-1];
          shadow_tag[pos]  = shadow_tag[pos-1];
          pos--;
        end
        shadow_prio[pos] = p;
        shadow_tag[pos]  = t;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.out_prio = shadow_prio[0];
        r.out_tag  = shadow_tag[0];
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_prio[i] = shadow_prio[i+1];
          shadow_tag[i]  = shadow_tag[i+1];
        end
        shadow_count--;
      end
    end
    r.fill = shadow_count[FILL_BITS-1:0];
    return r;
  endfunction

  task automatic report_field(input string fname, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
    end
  endtask

  // Result checker and cycle count
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst && res_valid && !res_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0h prio %0h tag %0h fill %0h",
                 $time, status, out_prio, out_tag, fill);
      end else begin
        want = pending_results.pop_front();
        report_field("status", 32'(want.status), 32'(status));
        report_field("out_prio", 32'(want.out_prio), 32'(out_prio));
        report_field("out_tag", want.out_tag, out_tag);
        report_field("fill", 32'(want.fill), 32'(fill));
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
      end
    end
  end

  // Result side stall: random, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one request, wait for it to be taken, and record what it must produce
  task automatic send_req(input logic k, input logic [PRIO_BITS-1:0] p,
                          input logic [TAG_BITS-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    kind      <= k;
    prio      <= p;
    tag       <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(queue_apply(k, p, t));
    n_requests++;
    @(negedge clk);
  endtask

  function automatic logic [PRIO_BITS-1:0] pick_prio();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return PRIO_BITS'($urandom_range(3));
    if (sel < 55) return '0;
    if (sel < 65) return '1;
    return PRIO_BITS'($urandom);
  endfunction

  // Empty remove, extremes, ties, full insert, then drain past empty
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_req(KIND_REMOVE, '1, '1);
    send_req(KIND_INSERT, '1, '1);
    send_req(KIND_INSERT, '0, '0);
    send_req(KIND_INSERT, 8'h80, 32'h1);
    send_req(KIND_INSERT, 8'h80, 32'h2);
    send_req(KIND_INSERT, 8'h80, 32'h3);
    send_req(KIND_INSERT, '0, 32'h5);
    send_req(KIND_INSERT, '1, 32'h6);
    send_req(KIND_INSERT, 8'h7f, 32'haaaa_aaaa);
    send_req(KIND_INSERT, 8'h01, 32'h5555_5555);
    for (int i = 0; i <= DEPTH; i++) send_req(KIND_REMOVE, 8'h55, 32'h1234_5678);
  endtask

  // Random traffic in runs that drift toward full, toward empty, or stay level
  task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
    int drift;
    int ins_pct;
    logic k;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    drift = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) drift = $urandom_range(2);
      ins_pct = (drift == 0) ? 50 : (drift == 1) ? 75 : 25;
      k = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
      send_req(k, pick_prio(), $urandom);
    end
  endtask

  // Hold the result side for a long stretch while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_req(($urandom_range(99) < 60) ? KIND_INSERT : KIND_REMOVE, pick_prio(), $urandom);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(32, 49, 200);
    test_random(49, 32, 200);
    test_random(0, 0, 200);
    test_backpressure();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("Ran %0d requests and checked %0d results in %0d cycles",
             n_requests, n_results, cycles);
    $display("Refused inserts on full queue: %0d, refused removes on empty queue: %0d",
             n_full, n_empty);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue.f @@
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
test/tb.sv
